/* sv/blvd_pkg.sv */
// Package for the bounded list with value delete.
// Holds the sizes, request and status codes, and the beat and command structs.
// No dependencies.
package blvd_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [CNT_W-1:0]              count_t;
    typedef logic [IDX_W-1:0]              index_t;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_DELETE     = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_PEEK       = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    // Request beat
    typedef struct packed {
        logic [2:0] req_type;
        value_t     item_value;
    } req_t;

    // Result beat
    typedef struct packed {
        logic [1:0] status;
        value_t     removed_value;
        value_t     first_value;
        value_t     last_value;
        logic       is_empty;
        count_t     entry_count;
    } result_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic   en;
        op_t    op;
        value_t value;
        count_t count;
    } cell_cmd_t;

endpackage

/* sv/blvd_cell.sv */
// One cell of the list chain: holds one entry and shifts with its neighbors.
// Depends on blvd_pkg.
module blvd_cell
(
    input  logic                clk,
    input  blvd_pkg::cell_cmd_t cmd,
    input  blvd_pkg::index_t    idx,
    input  blvd_pkg::value_t    left_value,
    input  blvd_pkg::value_t    right_value,
    input  logic                found_in,
    output blvd_pkg::value_t    value,
    output logic                found_out
);

    blvd_pkg::value_t value_reg;
    blvd_pkg::value_t value_next;
    logic             occupied;
    logic             full;
    logic             is_tail_slot;

    assign occupied     = {1'b0, idx} < cmd.count;
    assign full         = cmd.count == blvd_pkg::count_t'(blvd_pkg::CAPACITY);
    assign is_tail_slot = {1'b0, idx} == cmd.count;

    // Pass the first-match flag down the chain
    assign found_out = found_in | (occupied && (value_reg == cmd.value));

    // Select what this cell loads
    always_comb
    begin
        value_next = value_reg;
        if (cmd.en)
        begin
            case (cmd.op)
                blvd_pkg::OP_PUSH_BACK:
                begin
                    if (!full && is_tail_slot)
                        value_next = cmd.value;
                end
                blvd_pkg::OP_PUSH_FRONT:
                begin
                    if (!full)
                        value_next = (idx == '0) ? cmd.value : left_value;
                end
                blvd_pkg::OP_DELETE:
                begin
                    if (found_out)
                        value_next = right_value;
                end
                blvd_pkg::OP_POP_FRONT:
                begin
                    if (cmd.count != '0)
                        value_next = right_value;
                end
                default:
                begin
                    value_next = value_reg;
                end
            endcase
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* sv/bounded_list_with_value_delete.sv */
// Bounded list with value delete: a chain of cells plus count and result registers.
// The result beat shows on done in the cycle after start is taken.
// Throughput: one request per cycle; busy stays low, and all cells shift together as a request is taken.
// Reset: rst_n clears the count (list empty) and the done strobe; entries are not cleared.
// The receiver cannot stall; each result is valid only in its done cycle.
// Depends on blvd_pkg and blvd_cell.
module bounded_list_with_value_delete
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  blvd_pkg::req_t    req,
    output logic              done,
    output blvd_pkg::result_t result
);

    blvd_pkg::value_t    cell_value [blvd_pkg::CAPACITY];
    logic                found [blvd_pkg::CAPACITY+1];
    blvd_pkg::cell_cmd_t cmd;
    blvd_pkg::op_t       op;
    logic                accept;

    blvd_pkg::count_t    count_reg;
    blvd_pkg::count_t    count_next;
    logic                done_reg;
    blvd_pkg::status_t   status_reg;
    blvd_pkg::status_t   status_next;
    blvd_pkg::value_t    removed_reg;
    blvd_pkg::value_t    removed_next;
    blvd_pkg::value_t    last_value;
    logic                full;
    logic                empty;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign op     = blvd_pkg::op_t'(req.req_type);
    assign full   = count_reg == blvd_pkg::count_t'(blvd_pkg::CAPACITY);
    assign empty  = count_reg == '0;

    // Broadcast the command to the chain
    assign cmd.en    = accept;
    assign cmd.op    = op;
    assign cmd.value = req.item_value;
    assign cmd.count = count_reg;

    assign found[0] = 1'b0;

    // Build the row of cells
    for (genvar i = 0; i < blvd_pkg::CAPACITY; i++)
    begin : g_cell
        blvd_pkg::value_t left_v;
        blvd_pkg::value_t right_v;

        if (i == 0)
        begin : g_first
            assign left_v = req.item_value;
        end
        else
        begin : g_mid_l
            assign left_v = cell_value[i-1];
        end

        if (i == blvd_pkg::CAPACITY - 1)
        begin : g_last
            assign right_v = cell_value[i];
        end
        else
        begin : g_mid_r
            assign right_v = cell_value[i+1];
        end

        blvd_cell u_cell
        (
            .clk         (clk),
            .cmd         (cmd),
            .idx         (blvd_pkg::index_t'(i)),
            .left_value  (left_v),
            .right_value (right_v),
            .found_in    (found[i]),
            .value       (cell_value[i]),
            .found_out   (found[i+1])
        );
    end

    // Pick the back entry: the cell whose slot is count minus one
    always_comb
    begin
        last_value = '0;
        for (int i = 0; i < blvd_pkg::CAPACITY; i++)
        begin
            if (blvd_pkg::count_t'(i + 1) == count_reg)
                last_value = cell_value[i];
        end
    end

    // Decode the request into count, status and removed value
    always_comb
    begin
        count_next   = count_reg;
        status_next  = blvd_pkg::ST_DONE;
        removed_next = '0;
        unique case (op) inside
            blvd_pkg::OP_PUSH_BACK, blvd_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                    status_next = blvd_pkg::ST_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            blvd_pkg::OP_DELETE:
            begin
                if (found[blvd_pkg::CAPACITY])
                begin
                    count_next   = count_reg - 1'b1;
                    removed_next = req.item_value;
                end
                else
                    status_next = blvd_pkg::ST_MISS;
            end
            blvd_pkg::OP_POP_FRONT:
            begin
                if (empty)
                    status_next = blvd_pkg::ST_MISS;
                else
                begin
                    count_next   = count_reg - 1'b1;
                    removed_next = cell_value[0];
                end
            end
            blvd_pkg::OP_POP_BACK:
            begin
                if (empty)
                    status_next = blvd_pkg::ST_MISS;
                else
                begin
                    count_next   = count_reg - 1'b1;
                    removed_next = last_value;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Advance count and the done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
                count_reg <= count_next;
        end
    end

    // Capture the per-beat result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
    end

    // Drive the result beat from the updated list
    assign done                 = done_reg;
    assign result.status        = status_reg;
    assign result.removed_value = removed_reg;
    assign result.first_value   = empty ? '0 : cell_value[0];
    assign result.last_value    = empty ? '0 : last_value;
    assign result.is_empty      = empty;
    assign result.entry_count   = count_reg;

endmodule

/* sim/tb_bounded_list_with_value_delete.sv */
// Testbench for bounded_list_with_value_delete: directed and random request beats
// checked against a queue-based list predictor. Depends on blvd_pkg and the RTL.
module tb_bounded_list_with_value_delete;

    localparam logic [2:0] REQ_SPARE6  = 3'd6;
    localparam logic [2:0] REQ_SPARE7  = 3'd7;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         MAX_GAP     = 18;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} traffic_mix_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              done;
    blvd_pkg::req_t    req;
    blvd_pkg::result_t result;

    blvd_pkg::value_t  list_model[$];
    blvd_pkg::result_t pending_results[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      beats_checked = 0;
    int      requests_by_kind[8];
    int      full_rejects = 0;
    int      not_found = 0;
    int      full_visits = 0;
    bit      idle_on = 1'b1;

    bounded_list_with_value_delete dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Apply one request to the list model and return the result it should produce
    function automatic blvd_pkg::result_t apply_list_request(logic [2:0] kind,
                                                             blvd_pkg::value_t val);
        blvd_pkg::result_t r;
        int                hit;
        r = '0;
        r.status = blvd_pkg::ST_DONE;
        hit = -1;
        case (kind)
            blvd_pkg::OP_PUSH_BACK, blvd_pkg::OP_PUSH_FRONT:
            begin
                if (list_model.size() >= blvd_pkg::CAPACITY)
                    r.status = blvd_pkg::ST_FULL;
                else if (kind == blvd_pkg::OP_PUSH_BACK)
                    list_model.push_back(val);
                else
                    list_model.push_front(val);
            end
            blvd_pkg::OP_DELETE:
            begin
                foreach (list_model[i])
                    if (hit < 0 && list_model[i] == val)
                        hit = i;
                if (hit < 0)
                    r.status = blvd_pkg::ST_MISS;
                else
                begin
                    r.removed_value = list_model[hit];
                    list_model.delete(hit);
                end
            end
            blvd_pkg::OP_POP_FRONT:
            begin
                if (list_model.size() == 0)
                    r.status = blvd_pkg::ST_MISS;
                else
                    r.removed_value = list_model.pop_front();
            end
            blvd_pkg::OP_POP_BACK:
            begin
                if (list_model.size() == 0)
                    r.status = blvd_pkg::ST_MISS;
                else
                    r.removed_value = list_model.pop_back();
            end
            default:
                ; // peek and the spare codes leave the list alone
        endcase
        if (list_model.size() != 0)
        begin
            r.first_value = list_model[0];
            r.last_value  = list_model[list_model.size() - 1];
        end
        r.is_empty    = (list_model.size() == 0);
        r.entry_count = blvd_pkg::count_t'(list_model.size());
        return r;
    endfunction

    // Drive one request beat, hold it until taken, then log its expected result
    task automatic send_request(input logic [2:0] kind, input blvd_pkg::value_t val);
        int                gap;
        blvd_pkg::result_t want;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req   <= '{req_type: kind, item_value: val};
        do
            @(posedge clk);
        while (busy !== 1'b0);
        want = apply_list_request(kind, val);
        pending_results.push_back(want);
        requests_by_kind[kind]++;
        if (want.status == blvd_pkg::ST_FULL)
            full_rejects++;
        if (want.status == blvd_pkg::ST_MISS)
            not_found++;
        if (list_model.size() == blvd_pkg::CAPACITY)
            full_visits++;
        @(negedge clk);
    endtask

    // Hold the sender until every expected beat has come back
    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        blvd_pkg::result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                beats_checked++;
                check_field("status", 32'(want.status), 32'(result.status));
                check_field("removed_value", want.removed_value, result.removed_value);
                check_field("first_value", want.first_value, result.first_value);
                check_field("last_value", want.last_value, result.last_value);
                check_field("is_empty", 32'(want.is_empty), 32'(result.is_empty));
                check_field("entry_count", 32'(want.entry_count),
                            32'(result.entry_count));
            end
        end
    end

    function automatic blvd_pkg::value_t pick_value();
        case ($urandom_range(0, 9))
            0:       return blvd_pkg::value_t'(32'h7FFF_FFFF);
            1:       return blvd_pkg::value_t'(32'h8000_0000);
            2:       return blvd_pkg::value_t'(-1);
            3, 4, 5: return blvd_pkg::value_t'($urandom_range(0, 8) - 4);
            default: return blvd_pkg::value_t'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] pick_request(traffic_mix_t mix);
        int roll;
        int push_share;
        roll = $urandom_range(0, 99);
        push_share = (mix == MIX_GROW) ? 75 : (mix == MIX_SHRINK) ? 25 : 50;
        if (roll == 0)
            return REQ_SPARE6;
        if (roll == 1)
            return REQ_SPARE7;
        if (roll < 7)
            return blvd_pkg::OP_PEEK;
        if ($urandom_range(0, 99) < push_share)
            return $urandom_range(0, 1) ? blvd_pkg::OP_PUSH_BACK : blvd_pkg::OP_PUSH_FRONT;
        case ($urandom_range(0, 2))
            0:       return blvd_pkg::OP_DELETE;
            1:       return blvd_pkg::OP_POP_FRONT;
            default: return blvd_pkg::OP_POP_BACK;
        endcase
    endfunction

    // Empty list: peek, pops, delete and the spare codes all on nothing
    task automatic test_empty_list();
        send_request(blvd_pkg::OP_PEEK, blvd_pkg::value_t'(32'h1234_5678));
        send_request(blvd_pkg::OP_POP_FRONT, '0);
        send_request(blvd_pkg::OP_POP_BACK, blvd_pkg::value_t'(-1));
        send_request(blvd_pkg::OP_DELETE, '0);
        send_request(REQ_SPARE6, blvd_pkg::value_t'(32'h8000_0000));
        send_request(REQ_SPARE7, blvd_pkg::value_t'(32'h7FFF_FFFF));
    endtask

    // Extremes and duplicates, then fill and push into the full list at both ends
    task automatic test_fill_and_reject();
        send_request(blvd_pkg::OP_PUSH_BACK, blvd_pkg::value_t'(32'h7FFF_FFFF));
        send_request(blvd_pkg::OP_PUSH_FRONT, blvd_pkg::value_t'(32'h8000_0000));
        send_request(blvd_pkg::OP_PUSH_BACK, blvd_pkg::value_t'(-1));
        send_request(blvd_pkg::OP_PUSH_BACK, '0);
        send_request(blvd_pkg::OP_PUSH_BACK, blvd_pkg::value_t'(-1));
        while (list_model.size() < blvd_pkg::CAPACITY)
            send_request(blvd_pkg::OP_PUSH_FRONT, pick_value());
        send_request(blvd_pkg::OP_PUSH_BACK, blvd_pkg::value_t'(32'h5A5A_5A5A));
        send_request(blvd_pkg::OP_PUSH_FRONT, blvd_pkg::value_t'(32'hA5A5_A5A5));
    endtask

    // Delete the first of two equal entries, miss on an absent value, pop both ends
    task automatic test_delete_and_pops();
        send_request(blvd_pkg::OP_DELETE, blvd_pkg::value_t'(-1));
        send_request(blvd_pkg::OP_DELETE, blvd_pkg::value_t'(32'h0BAD_F00D));
        send_request(blvd_pkg::OP_POP_BACK, '0);
        send_request(blvd_pkg::OP_POP_FRONT, '0);
        wait_for_results();
    endtask

    // Phases that lean toward growing, shrinking or neither, so the list swings full and empty
    task automatic test_random_traffic(input int item_total);
        int               sent;
        int               phase_len;
        traffic_mix_t     mix;
        logic [2:0]       kind;
        blvd_pkg::value_t val;
        sent = 0;
        while (sent < item_total)
        begin
            phase_len = $urandom_range(15, 70);
            mix = traffic_mix_t'($urandom_range(0, 2));
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (phase_len)
            begin
                kind = pick_request(mix);
                val = pick_value();
                if (kind == blvd_pkg::OP_DELETE && list_model.size() != 0
                    && $urandom_range(0, 3) != 0)
                    val = list_model[$urandom_range(0, list_model.size() - 1)];
                send_request(kind, val);
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
                wait_for_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        foreach (requests_by_kind[k])
            requests_by_kind[k] = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_list();
        test_fill_and_reject();
        test_delete_and_pops();
        test_random_traffic(1120);

        // Drain and let the last beat settle
        wait_for_results();
        repeat (4) @(negedge clk);

        $display("Checked %0d result beats: push back/front %0d/%0d, delete %0d,",
                 beats_checked, requests_by_kind[blvd_pkg::OP_PUSH_BACK],
                 requests_by_kind[blvd_pkg::OP_PUSH_FRONT],
                 requests_by_kind[blvd_pkg::OP_DELETE]);
        $display("  pop front/back %0d/%0d, peek %0d, spare %0d.",
                 requests_by_kind[blvd_pkg::OP_POP_FRONT],
                 requests_by_kind[blvd_pkg::OP_POP_BACK],
                 requests_by_kind[blvd_pkg::OP_PEEK],
                 requests_by_kind[REQ_SPARE6] + requests_by_kind[REQ_SPARE7]);
        $display("Full-list rejects %0d, not-found misses %0d, full-list visits %0d.",
                 full_rejects, not_found, full_visits);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* bounded_list_with_value_delete.f */
sv/blvd_pkg.sv
sv/blvd_cell.sv
sv/bounded_list_with_value_delete.sv
sim/tb_bounded_list_with_value_delete.sv
